// File: hdl/pbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbr_pkg
// Types and constants shared by the base relocation parser modules.
// ----------------------------------------------------------------------------
package pbr_pkg;

   localparam int CSR_INDEX_W = 8;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_BASE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_BASE  = 8'd1;

   // relocation entry types
   localparam logic [3:0] RT_HIGH    = 4'd1;
   localparam logic [3:0] RT_LOW     = 4'd2;
   localparam logic [3:0] RT_HIGHLOW = 4'd3;
   localparam logic [3:0] RT_HIGHADJ = 4'd4;
   localparam logic [3:0] RT_DIR64   = 4'd10;

   // result kinds
   localparam logic KIND_PATCH = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   // patch widths
   localparam logic [1:0] WS_16 = 2'd0;
   localparam logic [1:0] WS_32 = 2'd1;
   localparam logic [1:0] WS_64 = 2'd2;

   // header steps; bit 2 set means entry halfwords
   localparam logic [2:0] HDR_RVA_LO  = 3'd0;
   localparam logic [2:0] HDR_RVA_HI  = 3'd1;
   localparam logic [2:0] HDR_SIZE_LO = 3'd2;
   localparam logic [2:0] HDR_SIZE_HI = 3'd3;
   localparam logic [2:0] HDR_ENTRIES = 3'd4;

   localparam logic [31:0] HDR_BYTES = 32'd8;

   typedef struct packed {
      logic        kind;
      logic [31:0] patch_rva;
      logic [1:0]  write_size;
      logic [63:0] addend;
   } result_type;

endpackage : pbr_pkg
`default_nettype wire

// File: hdl/pbr_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbr_parse
// Block header tracking and entry decode for one halfword per cycle while take is high.
// ----------------------------------------------------------------------------
module pbr_parse
   import pbr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        take,
   input  wire logic [15:0] half_word,
   input  wire logic        section_start,
   input  wire logic [63:0] current_base,
   input  wire logic [63:0] target_base,
   output      logic        result_valid,
   output      result_type  result
);

   logic [2:0]  header_step_ff, header_step_in;
   logic [31:0] page_rva_ff, page_rva_in;
   logic [15:0] size_low_ff, size_low_in;
   logic [30:0] entries_left_ff, entries_left_in;
   logic        skip_next_ff, skip_next_in;

   logic [2:0]  step;
   logic [30:0] left;
   logic        skip;
   logic [31:0] size;
   logic        bad;
   logic [31:0] size_body;
   logic [3:0]  etype;
   logic [63:0] delta;

   assign size      = {half_word, size_low_ff};
   assign size_body = size - HDR_BYTES;
   assign etype     = half_word[15:12];
   assign delta     = target_base - current_base;

   always_comb begin
      step = section_start ? HDR_RVA_LO : header_step_ff;
      left = section_start ? 31'd0 : entries_left_ff;
      skip = section_start ? 1'b0 : skip_next_ff;
      // block exhausted: next halfword is a header
      if (step[2] && (left == 31'd0)) begin
         step = HDR_RVA_LO;
         skip = 1'b0;
      end

      bad = (size < HDR_BYTES) || size[0];

      header_step_in  = step;
      page_rva_in     = page_rva_ff;
      size_low_in     = size_low_ff;
      entries_left_in = left;
      skip_next_in    = skip;
      result_valid    = 1'b0;
      result.kind       = KIND_PATCH;
      result.patch_rva  = page_rva_ff + {20'd0, half_word[11:0]};
      result.write_size = WS_16;
      result.addend     = 64'd0;

      if (step[2]) begin
         entries_left_in = left - 31'd1;
         skip_next_in    = 1'b0;
         if (!skip) begin
            case (etype)
               RT_HIGH: begin
                  result_valid  = 1'b1;
                  result.addend = {48'd0, delta[31:16]};
               end
               RT_LOW: begin
                  result_valid  = 1'b1;
                  result.addend = {48'd0, delta[15:0]};
               end
               RT_HIGHLOW: begin
                  result_valid      = 1'b1;
                  result.write_size = WS_32;
                  result.addend     = {32'd0, delta[31:0]};
               end
               RT_DIR64: begin
                  result_valid      = 1'b1;
                  result.write_size = WS_64;
                  result.addend     = delta;
               end
               RT_HIGHADJ: skip_next_in = 1'b1;
               default: ;
            endcase
         end
         if (entries_left_in == 31'd0) begin
            header_step_in = HDR_RVA_LO;
            skip_next_in   = 1'b0;
         end
      end else begin
         case (step)
            HDR_RVA_LO: begin
               page_rva_in    = {16'd0, half_word};
               header_step_in = HDR_RVA_HI;
            end
            HDR_RVA_HI: begin
               page_rva_in    = {half_word, page_rva_ff[15:0]};
               header_step_in = HDR_SIZE_LO;
            end
            HDR_SIZE_LO: begin
               size_low_in    = half_word;
               header_step_in = HDR_SIZE_HI;
            end
            default: begin
               entries_left_in = (size < HDR_BYTES) ? 31'd0 : size_body[31:1];
               skip_next_in    = 1'b0;
               header_step_in  = (entries_left_in != 31'd0) ? HDR_ENTRIES : HDR_RVA_LO;
               result_valid      = bad;
               result.kind       = KIND_ERROR;
               result.patch_rva  = page_rva_ff;
               result.write_size = WS_16;
               result.addend     = {32'd0, size};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_step_ff  <= HDR_RVA_LO;
         page_rva_ff     <= 32'd0;
         size_low_ff     <= 16'd0;
         entries_left_ff <= 31'd0;
         skip_next_ff    <= 1'b0;
      end else if (take) begin
         header_step_ff  <= header_step_in;
         page_rva_ff     <= page_rva_in;
         size_low_ff     <= size_low_in;
         entries_left_ff <= entries_left_in;
         skip_next_ff    <= skip_next_in;
      end
   end

endmodule : pbr_parse
`default_nettype wire

// File: hdl/pbr_rsp_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbr_rsp_reg
// Result register with valid/ready toward the consumer.
// ----------------------------------------------------------------------------
module pbr_rsp_reg
   import pbr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire logic       load_valid,
   input  wire result_type load_data,
   output      logic       free,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      result_type rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         data_ff <= load_data;
      end
   end

endmodule : pbr_rsp_reg
`default_nettype wire

// File: hdl/pe_base_reloc_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pe_base_reloc_parser
// Streaming parser for the PE base relocation section.
//
// req_*  : one little-endian halfword of the section per beat; section_start
//          puts the parser back at a block header before that halfword.
// rsp_*  : zero or one result per halfword: a patch command (rva, width,
//          addend from target_base - current_base) or a bad block size error.
// csr_*  : index 0 current_base, index 1 target_base; always ready, other
//          indexes are dropped. Write only while the parser is idle.
// A beat is captured in an input register, then decoded and loaded into the
// output register once that register is free; rsp_valid rises when a result
// lands there. One halfword per cycle is sustained while rsp_ready stays high;
// the limit is the single decode stage between the input and output registers.
// A stalled rsp_ready holds the output register; the input register still
// takes one more beat, then req_ready drops until the result is taken.
// Reset clears the parser to expect a block header and zeroes both bases.
// ----------------------------------------------------------------------------
module pe_base_reloc_parser
   import pbr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [15:0]            req_half_word,
   input  wire logic                   req_section_start,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic                   rsp_kind,
   output      logic [31:0]            rsp_patch_rva,
   output      logic [1:0]             rsp_write_size,
   output      logic [63:0]            rsp_addend,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]            csr_data
);

   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_half_word_ff;
   logic        in_start_ff;
   logic [63:0] current_base_ff;
   logic [63:0] target_base_ff;

   logic        out_free;
   logic        advance;
   logic        req_fire;
   logic        result_valid;
   result_type  result;
   result_type  rsp_data;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         current_base_ff <= 64'd0;
         target_base_ff  <= 64'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CURRENT_BASE: current_base_ff <= csr_data;
               CSR_TARGET_BASE:  target_base_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_half_word_ff <= req_half_word;
         in_start_ff     <= req_section_start;
      end
   end

   pbr_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .take          (advance),
      .half_word     (in_half_word_ff),
      .section_start (in_start_ff),
      .current_base  (current_base_ff),
      .target_base   (target_base_ff),
      .result_valid  (result_valid),
      .result        (result)
   );

   pbr_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (result_valid),
      .load_data  (result),
      .free       (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_kind       = rsp_data.kind;
   assign rsp_patch_rva  = rsp_data.patch_rva;
   assign rsp_write_size = rsp_data.write_size;
   assign rsp_addend     = rsp_data.addend;

endmodule : pe_base_reloc_parser
`default_nettype wire

// File: tb/tb_pe_base_reloc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pe_base_reloc_parser
// Self-checking bench for the base relocation parser. Halfword streams are
// driven through the req handshake and decoded by a cycle-free parser model
// kept in the bench. Each expected patch command or size error is queued and
// compared field by field with the rsp beats. Bases are rewritten between
// phases. Random gaps and stalls are injected on both sides.
// ----------------------------------------------------------------------------
module tb_pe_base_reloc_parser;
   import pbr_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS  = 10;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [15:0]            req_half_word = '0;
   logic                   req_section_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b1;
   logic                   rsp_kind;
   logic [31:0]            rsp_patch_rva;
   logic [1:0]             rsp_write_size;
   logic [63:0]            rsp_addend;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]            csr_data = '0;

   pe_base_reloc_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_half_word     (req_half_word),
      .req_section_start (req_section_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_patch_rva     (rsp_patch_rva),
      .rsp_write_size    (rsp_write_size),
      .rsp_addend        (rsp_addend),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   // parser model state
   logic [63:0] model_current_base = '0;
   logic [63:0] model_target_base  = '0;
   logic [2:0]  model_step         = HDR_RVA_LO;
   logic [31:0] model_page_rva     = '0;
   logic [15:0] model_size_lo      = '0;
   logic [30:0] model_entries_left = '0;
   logic        model_skip_next    = 1'b0;

   result_type patch_queue[$];

   int  items_sent    = 0;
   int  patches_seen  = 0;
   int  errors_seen   = 0;
   int  base_settings = 0;
   int  fail_count    = 0;
   int  cycle_count   = 0;
   bit  gaps_on       = 1'b1;
   bit  stalls_on     = 1'b1;
   int  stall_left    = 0;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   // Decode one accepted halfword and queue the result it should produce.
   task automatic parse_halfword(input logic [15:0] hw, input logic restart);
      logic [31:0] size;
      logic [31:0] rva;
      logic [63:0] delta;
      logic [3:0]  etype;
      logic        swallowed;
      if (restart) begin
         model_step         = HDR_RVA_LO;
         model_entries_left = '0;
         model_skip_next    = 1'b0;
      end
      if (model_step >= HDR_ENTRIES && model_entries_left == 0) begin
         model_step      = HDR_RVA_LO;
         model_skip_next = 1'b0;
      end
      case (model_step)
         HDR_RVA_LO: begin
            model_page_rva = {16'h0, hw};
            model_step     = HDR_RVA_HI;
         end
         HDR_RVA_HI: begin
            model_page_rva = {hw, model_page_rva[15:0]};
            model_step     = HDR_SIZE_LO;
         end
         HDR_SIZE_LO: begin
            model_size_lo = hw;
            model_step    = HDR_SIZE_HI;
         end
         HDR_SIZE_HI: begin
            size = {hw, model_size_lo};
            model_entries_left = (size >= HDR_BYTES) ? 31'((size - HDR_BYTES) >> 1) : '0;
            model_skip_next = 1'b0;
            model_step = (model_entries_left != 0) ? HDR_ENTRIES : HDR_RVA_LO;
            if (size < HDR_BYTES || size[0])
               patch_queue.push_back({KIND_ERROR, model_page_rva, WS_16, {32'h0, size}});
         end
         default: begin
            model_entries_left = model_entries_left - 1'b1;
            swallowed = model_skip_next;
            etype     = hw[15:12];
            rva       = model_page_rva + {20'h0, hw[11:0]};
            delta     = model_target_base - model_current_base;
            model_skip_next = 1'b0;
            if (!swallowed) begin
               case (etype)
                  RT_HIGH:
                     patch_queue.push_back({KIND_PATCH, rva, WS_16, {48'h0, delta[31:16]}});
                  RT_LOW:
                     patch_queue.push_back({KIND_PATCH, rva, WS_16, {48'h0, delta[15:0]}});
                  RT_HIGHLOW:
                     patch_queue.push_back({KIND_PATCH, rva, WS_32, {32'h0, delta[31:0]}});
                  RT_DIR64:
                     patch_queue.push_back({KIND_PATCH, rva, WS_64, delta});
                  RT_HIGHADJ:
                     model_skip_next = 1'b1;
                  default: ;
               endcase
            end
            if (model_entries_left == 0) begin
               model_step      = HDR_RVA_LO;
               model_skip_next = 1'b0;
            end
         end
      endcase
   endtask

   // valid is left high after a beat so back-to-back beats need no toggle
   task automatic send_halfword(input logic [15:0] hw, input logic restart);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_half_word     <= hw;
      req_section_start <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_halfword(hw, restart);
      items_sent++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_CURRENT_BASE)
         model_current_base = data;
      else if (idx == CSR_TARGET_BASE)
         model_target_base = data;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (patch_queue.size() != 0) @(posedge clock);
      // headers and skipped entries give no beat, let them settle
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_bases(input logic [63:0] cur, input logic [63:0] tgt);
      wait_idle();
      write_csr(CSR_CURRENT_BASE, cur);
      // unmapped index must be dropped
      write_csr(CSR_INDEX_W'($urandom_range(CSR_TARGET_BASE + 1, (1 << CSR_INDEX_W) - 1)),
                {$urandom(), $urandom()});
      write_csr(CSR_TARGET_BASE, tgt);
      csr_valid <= 1'b0;
      @(posedge clock);
      base_settings++;
   endtask

   task automatic send_reloc_block(input logic [31:0] page, input logic [31:0] size_bytes,
                                   input int n_entries, input logic restart);
      int i;
      send_halfword(page[15:0], restart);
      send_halfword(page[31:16], 1'b0);
      send_halfword(size_bytes[15:0], 1'b0);
      send_halfword(size_bytes[31:16], 1'b0);
      for (i = 0; i < n_entries; i++)
         send_halfword(random_entry(), 1'b0);
   endtask

   function automatic logic [15:0] random_entry();
      logic [3:0] etype;
      case ($urandom_range(0, 9))
         0, 1:    etype = RT_HIGHLOW;
         2:       etype = RT_HIGH;
         3:       etype = RT_LOW;
         4, 5:    etype = RT_DIR64;
         6:       etype = RT_HIGHADJ;
         default: etype = 4'($urandom_range(0, 15));
      endcase
      return {etype, 12'($urandom_range(0, 4095))};
   endfunction

   // one block with every patch type, a swallowed entry, rva wrap, trailing HIGHADJ
   task automatic test_entry_types();
      send_reloc_block(32'hFFFF_F800, 32'd22, 0, 1'b1);
      send_halfword({RT_HIGH, 12'hFFF}, 1'b0);
      send_halfword({RT_LOW, 12'h000}, 1'b0);
      send_halfword({RT_HIGHLOW, 12'h123}, 1'b0);
      send_halfword({RT_HIGHADJ, 12'h010}, 1'b0);
      send_halfword({RT_DIR64, 12'h020}, 1'b0);
      send_halfword({RT_DIR64, 12'hABC}, 1'b0);
      send_halfword({RT_HIGHADJ, 12'h7FF}, 1'b0);
   endtask

   // zero size, odd maximal size cut by a restart, then an empty 8-byte block
   task automatic test_block_sizes();
      send_reloc_block(32'h1234_5678, 32'd0, 0, 1'b0);
      send_reloc_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
      send_halfword(16'hFFFF, 1'b0);
      send_halfword(16'h0000, 1'b0);
      send_reloc_block(32'h0000_0000, HDR_BYTES, 0, 1'b1);
   endtask

   task automatic test_random_stream(input int n_items);
      int   stop_at;
      int   pick;
      int   n;
      int   i;
      logic restart;
      logic restart_due;
      stop_at     = items_sent + n_items;
      restart_due = 1'b1;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 19);
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         restart = restart_due || ($urandom_range(0, 3) == 0);
         restart_due = 1'b0;
         if (pick < 14)
            send_reloc_block($urandom(), 32'(HDR_BYTES + 2 * n), n, restart);
         else if (pick < 16) begin
            if ($urandom_range(0, 1))
               send_reloc_block($urandom(), 32'($urandom_range(0, 7)), 0, restart);
            else
               send_reloc_block($urandom(), 32'(HDR_BYTES + 2 * n + 1), n, restart);
         end else if (pick == 16) begin
            // oversized block, abandoned early
            send_reloc_block($urandom(), {16'($urandom_range(1, 65535)), 16'($urandom())},
                             $urandom_range(0, 6), restart);
            restart_due = 1'b1;
         end else if (pick == 17) begin
            send_reloc_block($urandom(), 32'(HDR_BYTES + 2 * (n + 1)),
                             $urandom_range(0, n), restart);
            restart_due = 1'b1;
         end else begin
            for (i = $urandom_range(1, 8); i > 0; i--)
               send_halfword(16'($urandom()), $urandom_range(0, 3) == 0);
            restart_due = 1'b1;
         end
      end
   endtask

   // rsp backpressure in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else if (stalls_on && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(1, 6);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_kind, rsp_patch_rva, rsp_write_size, rsp_addend};
         if (patch_queue.size() == 0) begin
            note_failure($sformatf("unexpected beat kind=%0d rva=%h ws=%0d addend=%h",
                                   got.kind, got.patch_rva, got.write_size, got.addend));
         end else begin
            want = patch_queue.pop_front();
            if (got.kind !== want.kind || got.patch_rva !== want.patch_rva ||
                got.write_size !== want.write_size || got.addend !== want.addend)
               note_failure($sformatf(
                  "exp kind=%0d rva=%h ws=%0d addend=%h, got kind=%0d rva=%h ws=%0d addend=%h",
                  want.kind, want.patch_rva, want.write_size, want.addend,
                  got.kind, got.patch_rva, got.write_size, got.addend));
            if (want.kind == KIND_ERROR)
               errors_seen++;
            else
               patches_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, patch_queue.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_bases(64'h0000_0000_0040_0000, 64'h1234_5678_9ABC_DEF0);
      test_entry_types();
      test_block_sizes();

      set_bases(64'h0, 64'h0);
      test_random_stream(325);

      set_bases(64'h0, {64{1'b1}});
      stalls_on = 1'b0;
      test_random_stream(325);

      set_bases({64{1'b1}}, 64'h0);
      gaps_on   = 1'b0;
      stalls_on = 1'b1;
      test_random_stream(325);

      set_bases({$urandom(), $urandom()}, {$urandom(), $urandom()});
      gaps_on = 1'b1;
      test_random_stream(325);

      // last stretch at full rate
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      set_bases({$urandom(), $urandom()}, {$urandom(), $urandom()});
      test_random_stream(325);

      wait_idle();
      repeat (10) @(posedge clock);

      $display("run covered %0d halfwords under %0d base settings", items_sent, base_settings);
      $display("checked %0d patch commands and %0d bad size beats, %0d mismatches",
               patches_seen, errors_seen, fail_count);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
